FILE: src/sbvs_pkg.sv
// Shared constants, register codes and stage types of the sphere brush core.
`default_nettype none

package sbvs_pkg;

   // Grid edge in voxels; coordinates at or above it are outside the grid.
   localparam int unsigned GRID_EDGE = 32;

   localparam int COORD_W    = 5;
   localparam int DENS_W     = 8;
   localparam int CENTER_W   = 11;
   localparam int RADIUS_W   = 6;
   localparam int DIFF_W     = 12;   // 16*vox - center, signed
   localparam int SQ_W       = 22;   // one squared difference
   localparam int SUM_W      = 23;   // sum of three squares
   localparam int RAD_W      = 24;   // radicand, padded to an even width
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int WEIGHT_W   = 6;    // soft weight 0..32
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [8:0] GRID_LIMIT = 9'(GRID_EDGE);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS   = 3'd3,
      CSR_ADD_MODE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic signed [CENTER_W-1:0] center_z;
      logic [RADIUS_W-1:0]        radius;
      logic                       add_mode;
   } brush_type;

   // Data one square-root cell hands to the next.
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [DENS_W-1:0] old_density;
      logic              in_grid;
   } slot_type;

endpackage

`default_nettype wire

FILE: src/sbvs_if.sv
// Request and response channel interfaces of the sphere brush core.
`default_nettype none

interface sbvs_req_if;
   logic                        valid;
   logic                        ready;
   logic [sbvs_pkg::COORD_W-1:0] vox_x;
   logic [sbvs_pkg::COORD_W-1:0] vox_y;
   logic [sbvs_pkg::COORD_W-1:0] vox_z;
   logic [sbvs_pkg::DENS_W-1:0]  old_density;

   modport source (output valid, vox_x, vox_y, vox_z, old_density, input ready);
   modport sink   (input valid, vox_x, vox_y, vox_z, old_density, output ready);
endinterface

interface sbvs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbvs_pkg::DENS_W-1:0]  new_density;
   logic                        touched;

   modport source (output valid, new_density, touched, input ready);
   modport sink   (input valid, new_density, touched, output ready);
endinterface

`default_nettype wire

FILE: src/sbvs_delta.sv
// Front stages: offsets to the centre, their squares, then the radicand.
`default_nettype none

module sbvs_delta (
   input  wire logic                clock,
   input  wire logic                reset,
   sbvs_req_if.sink                 req_chan,
   input  wire sbvs_pkg::brush_type brush,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output sbvs_pkg::slot_type       out_slot
);

   localparam int DIFF_W = sbvs_pkg::DIFF_W;

   logic signed [sbvs_pkg::DIFF_W-1:0]   dx, dy, dz;
   logic signed [2*sbvs_pkg::DIFF_W-1:0] px, py, pz;
   logic                                 in_grid;

   logic                              s1_valid_ff;
   logic [sbvs_pkg::SQ_W-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic [sbvs_pkg::DENS_W-1:0]       s1_old_ff;
   logic                              s1_grid_ff;

   logic                              s2_valid_ff;
   logic [sbvs_pkg::SUM_W-1:0]        sum_ff;
   logic [sbvs_pkg::DENS_W-1:0]       s2_old_ff;
   logic                              s2_grid_ff;

   logic s2_ready, s1_ready;

   assign s2_ready       = !s2_valid_ff || out_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   always_comb begin
      dx = $signed({3'b000, req_chan.vox_x, 4'b0000}) - DIFF_W'(brush.center_x);
      dy = $signed({3'b000, req_chan.vox_y, 4'b0000}) - DIFF_W'(brush.center_y);
      dz = $signed({3'b000, req_chan.vox_z, 4'b0000}) - DIFF_W'(brush.center_z);
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
      in_grid = ({4'b0000, req_chan.vox_x} < sbvs_pkg::GRID_LIMIT) &&
                ({4'b0000, req_chan.vox_y} < sbvs_pkg::GRID_LIMIT) &&
                ({4'b0000, req_chan.vox_z} < sbvs_pkg::GRID_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         sqx_ff     <= px[sbvs_pkg::SQ_W-1:0];
         sqy_ff     <= py[sbvs_pkg::SQ_W-1:0];
         sqz_ff     <= pz[sbvs_pkg::SQ_W-1:0];
         s1_old_ff  <= req_chan.old_density;
         s1_grid_ff <= in_grid;
      end
      if (s2_ready && s1_valid_ff) begin
         sum_ff     <= sbvs_pkg::SUM_W'(sqx_ff) + sbvs_pkg::SUM_W'(sqy_ff)
                     + sbvs_pkg::SUM_W'(sqz_ff);
         s2_old_ff  <= s1_old_ff;
         s2_grid_ff <= s1_grid_ff;
      end
   end

   always_comb begin
      out_valid            = s2_valid_ff;
      out_slot.rad         = sbvs_pkg::RAD_W'(sum_ff);
      out_slot.rem         = '0;
      out_slot.root        = '0;
      out_slot.old_density = s2_old_ff;
      out_slot.in_grid     = s2_grid_ff;
   end

endmodule

`default_nettype wire

FILE: src/sbvs_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per pass.
`default_nettype none

module sbvs_sqrt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire sbvs_pkg::slot_type up_slot,
   output logic                    down_valid,
   input  wire logic               down_ready,
   output sbvs_pkg::slot_type      down_slot
);

   localparam int REM_W  = sbvs_pkg::REM_W;
   localparam int ROOT_W = sbvs_pkg::ROOT_W;
   localparam int RAD_W  = sbvs_pkg::RAD_W;

   logic                     valid_ff;
   sbvs_pkg::slot_type       slot_ff;
   sbvs_pkg::slot_type       slot_in;
   logic [REM_W+1:0]         rem_sh;
   logic [REM_W+1:0]         trial;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      rem_sh  = {up_slot.rem, up_slot.rad[RAD_W-1 -: 2]};
      trial   = (REM_W + 2)'({up_slot.root, 2'b01});
      slot_in = up_slot;
      slot_in.rad = {up_slot.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         slot_in.rem  = REM_W'(rem_sh - trial);
         slot_in.root = {up_slot.root[ROOT_W-2:0], 1'b1};
      end else begin
         slot_in.rem  = REM_W'(rem_sh);
         slot_in.root = {up_slot.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) slot_ff <= slot_in;
   end

   assign down_valid = valid_ff;
   assign down_slot  = slot_ff;

endmodule

`default_nettype wire

FILE: src/sbvs_shade.sv
// Last stage: soft-edge weight, density limit and the response register.
`default_nettype none

module sbvs_shade (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbvs_pkg::brush_type brush,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire sbvs_pkg::slot_type  up_slot,
   sbvs_rsp_if.source               rsp_chan
);

   localparam int WEIGHT_W = sbvs_pkg::WEIGHT_W;
   localparam int DENS_W   = sbvs_pkg::DENS_W;

   logic signed [13:0]       dist16, outer, inner;
   logic signed [13:0]       diff;
   logic                     touched;
   logic [WEIGHT_W-1:0]      wn, mult;
   logic [13:0]              prod;
   logic [DENS_W-1:0]        lim, new_density;

   logic                     valid_ff;
   logic [DENS_W-1:0]        density_ff;
   logic                     touched_ff;

   assign up_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      dist16 = $signed({2'b00, up_slot.root});
      outer  = $signed({3'b000, ({1'b0, brush.radius} + 7'd1), 4'b0000});
      inner  = $signed({3'b000, {1'b0, brush.radius}, 4'b0000}) - 14'sd16;
      diff   = dist16 - inner;
      touched = up_slot.in_grid && (dist16 <= outer);
      wn    = (dist16 >= inner) ? WEIGHT_W'(diff) : '0;
      mult  = brush.add_mode ? (WEIGHT_W'(32) - wn) : wn;
      // times 255, then truncating divide by 32
      prod  = {mult, 8'h00} - 14'(mult);
      lim   = prod[12:5];
      new_density = up_slot.old_density;
      if (touched) begin
         if (brush.add_mode)
            new_density = (up_slot.old_density > lim) ? up_slot.old_density : lim;
         else
            new_density = (up_slot.old_density < lim) ? up_slot.old_density : lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         density_ff <= new_density;
         touched_ff <= touched;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.new_density = density_ff;
   assign rsp_chan.touched     = touched_ff;

endmodule

`default_nettype wire

FILE: src/sphere_brush_voxel_sculpt_core.sv
// Sphere brush voxel sculpt core: config registers and the full stage chain.
// Pipeline: 15 stage registers (2 offset/square, 12 square-root cells, 1 shading), in order.
// Throughput: one request per cycle; each stage has its own valid, bubbles collapse
//   and requests keep entering while a response waits until every stage is full.
// Reset (synchronous, active high) empties every stage; brush = centre 0, radius 1, remove.
`default_nettype none

module sphere_brush_voxel_sculpt_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sbvs_req_if.sink                                req_chan,
   sbvs_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [sbvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CELLS = sbvs_pkg::SQRT_CELLS;

   // Brush registers; write them only while the core is idle (the core does not enforce it).
   sbvs_pkg::brush_type brush_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brush_ff.center_x <= '0;
         brush_ff.center_y <= '0;
         brush_ff.center_z <= '0;
         brush_ff.radius   <= sbvs_pkg::RADIUS_W'(1);
         brush_ff.add_mode <= 1'b0;
      end else if (csr_we) begin
         unique case (sbvs_pkg::csr_index_type'(csr_index))
            sbvs_pkg::CSR_CENTER_X: brush_ff.center_x <= $signed(csr_wdata);
            sbvs_pkg::CSR_CENTER_Y: brush_ff.center_y <= $signed(csr_wdata);
            sbvs_pkg::CSR_CENTER_Z: brush_ff.center_z <= $signed(csr_wdata);
            sbvs_pkg::CSR_RADIUS:   brush_ff.radius   <= csr_wdata[sbvs_pkg::RADIUS_W-1:0];
            sbvs_pkg::CSR_ADD_MODE: brush_ff.add_mode <= csr_wdata[0];
            default: ;   // unused indexes are ignored
         endcase
      end
   end

   // Links of the chain: link 0 is the front output, link CELLS feeds shading.
   logic               link_valid [CELLS+1];
   logic               link_ready [CELLS+1];
   sbvs_pkg::slot_type link_slot  [CELLS+1];

   // Offsets, squares and their sum: two stages.
   sbvs_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .brush     (brush_ff),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_slot  (link_slot[0])
   );

   // Square-root chain, one root bit per cell, most significant first.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      sbvs_sqrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[i]),
         .up_ready   (link_ready[i]),
         .up_slot    (link_slot[i]),
         .down_valid (link_valid[i+1]),
         .down_ready (link_ready[i+1]),
         .down_slot  (link_slot[i+1])
      );
   end

   // Distance now sits in the root field: weight, clamp, response register.
   sbvs_shade u_shade (
      .clock    (clock),
      .reset    (reset),
      .brush    (brush_ff),
      .up_valid (link_valid[CELLS]),
      .up_ready (link_ready[CELLS]),
      .up_slot  (link_slot[CELLS]),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: src/sbvs_checker.sv
// Port checker for the sphere brush core, bound to its top level.
`default_nettype none

module sbvs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_new_density,
   input wire logic       rsp_touched
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_new_density) && $stable(rsp_touched))
      else $error("response payload changed while stalled");

   // The core refuses requests only when every stage is full and the output stalls.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output back-pressure");

   // Reset empties the chain: no response in the cycle after it.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present right after reset");

endmodule

bind sphere_brush_voxel_sculpt_core sbvs_checker u_sbvs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_new_density (rsp_chan.new_density),
   .rsp_touched     (rsp_chan.touched)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the sphere brush voxel sculpt core.
`timescale 1ns / 1ps

module testbench;
   import sbvs_pkg::*;

   localparam int CLK_HALF   = 6;       // 12 ns period
   localparam int TAIL_WAIT  = 24;      // cycles after the last response
   localparam int LONG_HOLD  = 80;      // long response back-pressure, well past pipe depth
   localparam int HOLD_AFTER = 150;     // responses seen before the long hold kicks in

   // One voxel request as the sender sees it.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [DENS_W-1:0]  density;
   } voxel_t;

   // Brushed density and touch flag expected back for one voxel.
   typedef struct packed {
      logic [DENS_W-1:0] new_density;
      logic              touched;
   } voxel_result_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sbvs_req_if voxel_req ();
   sbvs_rsp_if voxel_rsp ();

   sphere_brush_voxel_sculpt_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (voxel_req),
      .rsp_chan  (voxel_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Voxels waiting to be offered, and brushed results waiting to come back.
   voxel_t        voxel_feed_q[$];
   voxel_result_t brushed_q[$];

   // Testbench copy of the brush registers; only changed while the core is idle.
   brush_type brush_cfg = '{center_x: '0, center_y: '0, center_z: '0,
                            radius: 6'd1, add_mode: 1'b0};

   int  errors;
   int  voxels_in;
   int  voxels_back;
   int  voxels_touched;
   int  input_blocked;
   int  brush_settings = 1;   // reset values count as the first setting
   bit  no_idle;              // final stretch runs both sides flat out
   bit  req_taken;            // request accepted at the last rising edge
   int  send_gap;
   int  stall_left;
   int  hold_left;
   bit  long_hold_done;

   // ---------------------------------------------------------------------
   // Brush predictor
   // ---------------------------------------------------------------------

   // Truncated integer square root, one result bit per pass (root < 4096).
   function automatic int unsigned floor_root(int unsigned n);
      int unsigned r;
      int unsigned c;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         c = r | (32'd1 << b);
         if (c * c <= n)
            r = c;
      end
      return r;
   endfunction

   // Distance in sixteenths of a voxel, then the soft-edge weight wn in 0..32
   // (w = wn/32). Add mode floors the density at (1-w)*255, remove mode caps
   // it at w*255; both truncate.
   function automatic voxel_result_t brush_voxel(voxel_t v, brush_type b);
      int dx, dy, dz;
      int dist16, outer, inner, wn, lim;
      voxel_result_t r;
      r.new_density = v.density;
      r.touched     = 1'b0;
      // Voxels outside the grid pass untouched (cannot occur with 5-bit fields).
      if (v.x < GRID_EDGE && v.y < GRID_EDGE && v.z < GRID_EDGE) begin
         dx     = int'(v.x) * 16 - int'(b.center_x);
         dy     = int'(v.y) * 16 - int'(b.center_y);
         dz     = int'(v.z) * 16 - int'(b.center_z);
         dist16 = int'(floor_root(dx * dx + dy * dy + dz * dz));
         outer  = (int'(b.radius) + 1) * 16;
         inner  = (int'(b.radius) - 1) * 16;   // negative for a zero radius
         if (dist16 <= outer) begin
            r.touched = 1'b1;
            wn = (dist16 >= inner) ? dist16 - inner : 0;
            if (b.add_mode) begin
               lim = ((32 - wn) * 255) >> 5;
               if (lim > int'(v.density))
                  r.new_density = 8'(lim);
            end else begin
               lim = (wn * 255) >> 5;
               if (lim < int'(v.density))
                  r.new_density = 8'(lim);
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Every input known from time zero.
   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_CENTER_X;
      csr_wdata             = '0;
      voxel_req.valid       = 1'b0;
      voxel_req.vox_x       = '0;
      voxel_req.vox_y       = '0;
      voxel_req.vox_z       = '0;
      voxel_req.old_density = '0;
      voxel_rsp.ready       = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Request driver: falling edge, valid held until accepted
   // ---------------------------------------------------------------------

   always @(negedge clock) begin : feed_drive
      voxel_t v;
      if (reset) begin
         voxel_req.valid <= 1'b0;
      end else if (!voxel_req.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap        <= send_gap - 1;
            voxel_req.valid <= 1'b0;
         end else if (voxel_feed_q.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            // idle burst of random length between requests
            send_gap        <= $urandom_range(0, 6);
            voxel_req.valid <= 1'b0;
         end else if (voxel_feed_q.size() != 0) begin
            v = voxel_feed_q.pop_front();
            voxel_req.valid       <= 1'b1;
            voxel_req.vox_x       <= v.x;
            voxel_req.vox_y       <= v.y;
            voxel_req.vox_z       <= v.z;
            voxel_req.old_density <= v.density;
         end else begin
            voxel_req.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response sink: random stall bursts plus one long hold that backs the
   // pipe up until the core drops req ready while requests keep coming.
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         voxel_rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left       <= hold_left - 1;
         voxel_rsp.ready <= 1'b0;
      end else if (!long_hold_done && voxels_back >= HOLD_AFTER) begin
         long_hold_done  <= 1'b1;
         hold_left       <= LONG_HOLD - 1;
         voxel_rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left      <= stall_left - 1;
         voxel_rsp.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         stall_left      <= $urandom_range(0, 6);
         voxel_rsp.ready <= 1'b0;
      end else begin
         voxel_rsp.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on request accept, check on response accept
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : watch
      voxel_t        v;
      voxel_result_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= voxel_req.valid && voxel_req.ready;
         if (voxel_req.valid && voxel_req.ready) begin
            v = '{voxel_req.vox_x, voxel_req.vox_y, voxel_req.vox_z, voxel_req.old_density};
            brushed_q.push_back(brush_voxel(v, brush_cfg));
            voxels_in++;
         end
         if (voxel_req.valid && !voxel_req.ready)
            input_blocked++;
         if (voxel_rsp.valid && voxel_rsp.ready) begin
            voxels_back++;
            if (brushed_q.size() == 0) begin
               $error("response with no request outstanding: new_density=%0d touched=%0d",
                      voxel_rsp.new_density, voxel_rsp.touched);
               errors++;
            end else begin
               want = brushed_q.pop_front();
               if (want.touched)
                  voxels_touched++;
               if (voxel_rsp.new_density !== want.new_density) begin
                  $error("new_density: expected %0d, got %0d",
                         want.new_density, voxel_rsp.new_density);
                  errors++;
               end
               if (voxel_rsp.touched !== want.touched) begin
                  $error("touched: expected %0d, got %0d", want.touched, voxel_rsp.touched);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic push_voxel(int x, int y, int z, int d);
      voxel_feed_q.push_back('{5'(x), 5'(y), 5'(z), 8'(d)});
   endtask

   // Every request yields a response, so an empty expectation queue with
   // nothing left to send means the pipe is empty.
   task automatic wait_idle();
      while (voxel_feed_q.size() != 0 || voxel_req.valid || brushed_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program all five brush registers, then mirror them in the predictor.
   task automatic set_brush(brush_type b);
      wait_idle();
      write_reg(CSR_CENTER_X, b.center_x);
      write_reg(CSR_CENTER_Y, b.center_y);
      write_reg(CSR_CENTER_Z, b.center_z);
      write_reg(CSR_RADIUS,   CSR_DATA_W'(b.radius));
      write_reg(CSR_ADD_MODE, CSR_DATA_W'(b.add_mode));
      @(negedge clock);
      csr_we    <= 1'b0;
      brush_cfg  = b;
      brush_settings++;
   endtask

   // Centre mostly inside the grid; radius mostly small, sometimes anything.
   function automatic brush_type random_brush();
      brush_type b;
      b.center_x = CENTER_W'(int'($urandom_range(0, 560)) - 32);
      b.center_y = CENTER_W'(int'($urandom_range(0, 560)) - 32);
      b.center_z = CENTER_W'(int'($urandom_range(0, 560)) - 32);
      b.radius   = ($urandom_range(0, 3) == 0) ? RADIUS_W'($urandom_range(0, 63))
                                               : RADIUS_W'($urandom_range(0, 12));
      b.add_mode = 1'($urandom_range(0, 1));
      return b;
   endfunction

   // Coordinate within radius+2 voxels of the centre, clamped to the grid.
   function automatic logic [COORD_W-1:0] aim_coord(logic signed [CENTER_W-1:0] center,
                                                   int span);
      int p;
      p = ((int'(center) + 8) >>> 4) + int'($urandom_range(0, 2 * span)) - span;
      if (p < 0)
         p = 0;
      if (p > 31)
         p = 31;
      return COORD_W'(p);
   endfunction

   // Most voxels land on or near the sphere so the soft edge and the inner
   // core get real traffic; the rest are spread over the whole grid.
   task automatic queue_random(int count);
      voxel_t v;
      int     span;
      span = int'(brush_cfg.radius) + 2;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            v.x = aim_coord(brush_cfg.center_x, span);
            v.y = aim_coord(brush_cfg.center_y, span);
            v.z = aim_coord(brush_cfg.center_z, span);
         end else begin
            v.x = COORD_W'($urandom);
            v.y = COORD_W'($urandom);
            v.z = COORD_W'($urandom);
         end
         case ($urandom_range(0, 7))
            0:       v.density = 8'd0;
            1:       v.density = 8'd255;
            default: v.density = DENS_W'($urandom);
         endcase
         voxel_feed_q.push_back(v);
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin
      brush_type b;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset brush: centre at the origin, radius 1, remove mode.
      // Inner edge at 0, outer edge at 32 sixteenths.
      push_voxel(0, 0, 0, 255);      // dead centre, weight 0 -> cleared
      push_voxel(1, 0, 0, 255);      // half-way through the soft edge
      push_voxel(0, 1, 1, 255);      // non-integer distance, truncated root
      push_voxel(2, 0, 0, 255);      // exactly on the outer edge, still touched
      push_voxel(2, 0, 0, 0);
      push_voxel(1, 1, 1, 200);      // cap above the old density
      push_voxel(0, 2, 0, 128);      // outer edge on another axis
      push_voxel(2, 1, 0, 77);       // just outside -> passes through
      push_voxel(31, 31, 31, 255);   // far corner
      push_voxel(31, 0, 0, 0);
      push_voxel(0, 31, 0, 170);
      push_voxel(0, 0, 31, 85);

      // Zero radius, add mode: every touched voxel is in the soft edge.
      set_brush('{11'sd80, 11'sd80, 11'sd80, 6'd0, 1'b1});
      push_voxel(5, 5, 5, 0);        // centre, weight 1/2 -> floor of 127
      push_voxel(5, 5, 5, 255);
      push_voxel(6, 5, 5, 40);       // outer edge, weight 1 -> unchanged
      push_voxel(5, 5, 6, 0);
      push_voxel(5, 4, 5, 100);
      push_voxel(4, 5, 5, 10);
      push_voxel(6, 6, 5, 3);        // beyond the edge
      push_voxel(0, 0, 0, 3);
      push_voxel(31, 31, 31, 250);
      push_voxel(5, 5, 5, 127);

      // Random brushes; the long response hold lands in the first of these.
      set_brush(random_brush());
      queue_random(250);

      // Register extremes: most positive centre x, largest radius, remove.
      set_brush('{11'sd1023, 11'sd0, 11'sd255, 6'd63, 1'b0});
      queue_random(60);

      // Most negative centre x (-1024), negative centre z (-16), near-max radius, add.
      set_brush('{11'h400, 11'sd496, 11'h7F0, 6'd62, 1'b1});
      queue_random(60);

      // Zero radius in remove mode at a random centre.
      b          = random_brush();
      b.radius   = '0;
      b.add_mode = 1'b0;
      set_brush(b);
      queue_random(80);

      set_brush(random_brush());
      queue_random(120);

      // Final stretch with no idling on either side.
      set_brush(random_brush());
      no_idle = 1'b1;
      queue_random(110);

      wait_idle();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Brushed %0d voxels (%0d inside radius+1) under %0d brush settings;",
               voxels_in, voxels_touched, brush_settings);
      $display("request input was held off by back-pressure for %0d cycles.", input_blocked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: stops a hung run and reports it as failed.
   initial begin
      #(200_000 * 2 * CLK_HALF);
      $display("run timed out with %0d responses outstanding", brushed_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
src/sbvs_pkg.sv
src/sbvs_if.sv
src/sbvs_delta.sv
src/sbvs_sqrt_cell.sv
src/sbvs_shade.sv
src/sphere_brush_voxel_sculpt_core.sv
src/sbvs_checker.sv
verif/testbench.sv
